FILE: design/sm4c_pkg.sv
// Shared types, constants and functions of the SM4 counter-mode cipher.
// Holds the S-box, key schedule constants and the core control structs.
// Depends on nothing; every other design file imports it.
package sm4c_pkg;

  localparam int BLOCK_BYTES = 16;
  localparam int COUNT_W     = 5;
  localparam int ROUNDS      = 32;
  localparam int ROUND_W     = $clog2(ROUNDS);

  localparam logic [31:0] FK [4] = '{32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC};

  localparam logic [7:0] SBOX [256] = '{
    8'hD6, 8'h90, 8'hE9, 8'hFE, 8'hCC, 8'hE1, 8'h3D, 8'hB7,
    8'h16, 8'hB6, 8'h14, 8'hC2, 8'h28, 8'hFB, 8'h2C, 8'h05,
    8'h2B, 8'h67, 8'h9A, 8'h76, 8'h2A, 8'hBE, 8'h04, 8'hC3,
    8'hAA, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
    8'h9C, 8'h42, 8'h50, 8'hF4, 8'h91, 8'hEF, 8'h98, 8'h7A,
    8'h33, 8'h54, 8'h0B, 8'h43, 8'hED, 8'hCF, 8'hAC, 8'h62,
    8'hE4, 8'hB3, 8'h1C, 8'hA9, 8'hC9, 8'h08, 8'hE8, 8'h95,
    8'h80, 8'hDF, 8'h94, 8'hFA, 8'h75, 8'h8F, 8'h3F, 8'hA6,
    8'h47, 8'h07, 8'hA7, 8'hFC, 8'hF3, 8'h73, 8'h17, 8'hBA,
    8'h83, 8'h59, 8'h3C, 8'h19, 8'hE6, 8'h85, 8'h4F, 8'hA8,
    8'h68, 8'h6B, 8'h81, 8'hB2, 8'h71, 8'h64, 8'hDA, 8'h8B,
    8'hF8, 8'hEB, 8'h0F, 8'h4B, 8'h70, 8'h56, 8'h9D, 8'h35,
    8'h1E, 8'h24, 8'h0E, 8'h5E, 8'h63, 8'h58, 8'hD1, 8'hA2,
    8'h25, 8'h22, 8'h7C, 8'h3B, 8'h01, 8'h21, 8'h78, 8'h87,
    8'hD4, 8'h00, 8'h46, 8'h57, 8'h9F, 8'hD3, 8'h27, 8'h52,
    8'h4C, 8'h36, 8'h02, 8'hE7, 8'hA0, 8'hC4, 8'hC8, 8'h9E,
    8'hEA, 8'hBF, 8'h8A, 8'hD2, 8'h40, 8'hC7, 8'h38, 8'hB5,
    8'hA3, 8'hF7, 8'hF2, 8'hCE, 8'hF9, 8'h61, 8'h15, 8'hA1,
    8'hE0, 8'hAE, 8'h5D, 8'hA4, 8'h9B, 8'h34, 8'h1A, 8'h55,
    8'hAD, 8'h93, 8'h32, 8'h30, 8'hF5, 8'h8C, 8'hB1, 8'hE3,
    8'h1D, 8'hF6, 8'hE2, 8'h2E, 8'h82, 8'h66, 8'hCA, 8'h60,
    8'hC0, 8'h29, 8'h23, 8'hAB, 8'h0D, 8'h53, 8'h4E, 8'h6F,
    8'hD5, 8'hDB, 8'h37, 8'h45, 8'hDE, 8'hFD, 8'h8E, 8'h2F,
    8'h03, 8'hFF, 8'h6A, 8'h72, 8'h6D, 8'h6C, 8'h5B, 8'h51,
    8'h8D, 8'h1B, 8'hAF, 8'h92, 8'hBB, 8'hDD, 8'hBC, 8'h7F,
    8'h11, 8'hD9, 8'h5C, 8'h41, 8'h1F, 8'h10, 8'h5A, 8'hD8,
    8'h0A, 8'hC1, 8'h31, 8'h88, 8'hA5, 8'hCD, 8'h7B, 8'hBD,
    8'h2D, 8'h74, 8'hD0, 8'h12, 8'hB8, 8'hE5, 8'hB4, 8'hB0,
    8'h89, 8'h69, 8'h97, 8'h4A, 8'h0C, 8'h96, 8'h77, 8'h7E,
    8'h65, 8'hB9, 8'hF1, 8'h09, 8'hC5, 8'h6E, 8'hC6, 8'h84,
    8'h18, 8'hF0, 8'h7D, 8'hEC, 8'h3A, 8'hDC, 8'h4D, 8'h20,
    8'h79, 8'hEE, 8'h5F, 8'h3E, 8'hD7, 8'hCB, 8'h39, 8'h48
  };

  typedef enum logic [1:0] {
    REG_KEY_HIGH   = 2'd0,
    REG_KEY_LOW    = 2'd1,
    REG_NONCE_HIGH = 2'd2,
    REG_NONCE_LOW  = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_EXPAND,
    CORE_ENCRYPT
  } core_state_t;

  typedef struct packed {
    logic start_expand;
    logic start_encrypt;
  } core_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_status_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // Nonlinear layer: S-box on each byte.
  function automatic logic [31:0] tau(input logic [31:0] v);
    return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  // Key schedule constant: byte j of word i is (4i+j)*7 mod 256.
  function automatic logic [31:0] ck_word(input logic [ROUND_W-1:0] i);
    logic [31:0] w;
    logic [9:0]  prod;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      prod = 10'({i, 2'(j)}) * 10'd7;
      w = {w[23:0], prod[7:0]};
    end
    return w;
  endfunction

endpackage

FILE: design/sm4_ctr_stream_cipher.sv
// SM4 counter-mode cipher: one 16-byte request in, one result out.
// A request runs 32 rounds through one round unit that reads one round key per cycle
// from the round key memory; the core's done flag, the result_wait flag and the output
// register then follow in that order. A new request is taken only once the previous
// block has moved to the output register; a stalled result holds the request side.
// Reset is synchronous; after reset and after every key register write the key
// schedule runs, and requests stall until it finishes.
module sm4_ctr_stream_cipher (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        write_enable,
  input  logic [1:0]  write_index,
  input  logic [63:0] write_data,
  // request channel
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [63:0] data_high,
  input  logic [63:0] data_low,
  input  logic [4:0]  byte_count,
  input  logic        first_block,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [63:0] result_high,
  output logic [63:0] result_low,
  output logic [4:0]  result_bytes
);
  import sm4c_pkg::*;

  // Configuration registers.
  logic [63:0] key_high, key_low, nonce_high, nonce_low;

  // Control flags.
  logic expand_pending;  // key schedule must (re)run from the key registers
  logic in_flight;       // a request is in the core or waiting for the output register
  logic result_wait;     // core holds a finished keystream block
  logic out_full;        // output register holds a result

  // Block counter, big-endian 128-bit value split in two words.
  logic [63:0] ctr_high, ctr_low;
  logic [63:0] base_high, base_low;

  // Request payload kept while the core works.
  logic [63:0]        item_high, item_low;
  logic [COUNT_W-1:0] item_bytes;
  logic [COUNT_W-1:0] bytes_sat;

  logic         data_take, result_take, xfer, key_write;
  core_ctrl_t   core_ctrl;
  core_status_t core_status;
  logic [127:0] keystream;
  logic [127:0] byte_mask;

  assign key_write = write_enable &&
                     ((write_index == REG_KEY_HIGH) || (write_index == REG_KEY_LOW));

  // Hold requests while the key schedule is pending or running, or a request is open.
  assign data_stall  = expand_pending || in_flight || core_status.busy;
  assign data_take   = data_valid && !data_stall;
  assign result_take = result_valid && !result_stall;
  // Move the finished block into the output register once it is free or being drained.
  assign xfer        = result_wait && (!out_full || result_take);

  // A first block restarts from the nonce.
  assign base_high = first_block ? nonce_high : ctr_high;
  assign base_low  = first_block ? nonce_low  : ctr_low;

  // Saturate byte counts above a full block.
  assign bytes_sat = (byte_count > COUNT_W'(BLOCK_BYTES)) ? COUNT_W'(BLOCK_BYTES) : byte_count;

  assign core_ctrl.start_expand  = expand_pending;
  assign core_ctrl.start_encrypt = data_take;

  sm4c_core u_core (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (core_ctrl),
    .key       ({key_high, key_low}),
    .block_in  ({base_high, base_low}),
    .status    (core_status),
    .block_out (keystream)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high   <= '0;
      key_low    <= '0;
      nonce_high <= '0;
      nonce_low  <= '0;
    end else if (write_enable) begin
      case (write_index)
        REG_KEY_HIGH:   key_high   <= write_data;
        REG_KEY_LOW:    key_low    <= write_data;
        REG_NONCE_HIGH: nonce_high <= write_data;
        REG_NONCE_LOW:  nonce_low  <= write_data;
        default: ;
      endcase
    end
  end

  // After reset, expand the all-zero key so the round key memory is never read unwritten.
  always_ff @(posedge clk) begin
    if (rst) expand_pending <= 1'b1;
    else if (key_write) expand_pending <= 1'b1;
    else expand_pending <= 1'b0;
  end

  // Advance the counter on every accepted request; carry into the high word.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctr_high <= '0;
      ctr_low  <= '0;
    end else if (data_take) begin
      ctr_low  <= base_low + 64'd1;
      ctr_high <= base_high + {63'd0, &base_low};
    end
  end

  always_ff @(posedge clk) begin
    if (data_take) begin
      item_high  <= data_high;
      item_low   <= data_low;
      item_bytes <= bytes_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight   <= 1'b0;
      result_wait <= 1'b0;
      out_full    <= 1'b0;
    end else begin
      if (data_take) in_flight <= 1'b1;
      else if (xfer) in_flight <= 1'b0;

      if (core_status.done) result_wait <= 1'b1;
      else if (xfer) result_wait <= 1'b0;

      if (xfer) out_full <= 1'b1;
      else if (result_take) out_full <= 1'b0;
    end
  end

  // Keep the leading valid bytes, drop the rest.
  always_comb begin
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      byte_mask[127 - 8*i -: 8] = (COUNT_W'(i) < item_bytes) ? 8'hFF : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      result_high  <= (item_high ^ keystream[127:64]) & byte_mask[127:64];
      result_low   <= (item_low  ^ keystream[63:0])   & byte_mask[63:0];
      result_bytes <= item_bytes;
    end
  end

  assign result_valid = out_full;

endmodule

FILE: design/sm4c_core.sv
// Iterative SM4 core: one shared round unit for key expansion and block encryption.
// Round keys live in a 32-entry synchronous memory with a registered read port.
// Depends on sm4c_pkg.
module sm4c_core (
  input  logic                clk,
  input  logic                rst,
  input  sm4c_pkg::core_ctrl_t   ctrl,
  input  logic [127:0]        key,
  input  logic [127:0]        block_in,
  output sm4c_pkg::core_status_t status,
  output logic [127:0]        block_out
);
  import sm4c_pkg::*;

  localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);

  core_state_t        state, state_next;
  logic [ROUND_W-1:0] round;
  logic [31:0]        w0, w1, w2, w3;
  logic               done;

  logic [31:0]        rk_mem [ROUNDS];
  logic [31:0]        rk_rdata;
  logic [ROUND_W-1:0] rk_raddr;

  logic [31:0]        kin, mix, sub, lin, nw;
  logic               expanding;

  assign expanding = (state == CORE_EXPAND);

  // Prefetch the key of the next round; in idle and during expansion sit on round zero.
  assign rk_raddr = (state == CORE_ENCRYPT) ? round + 1'b1 : '0;

  assign kin = expanding ? ck_word(round) : rk_rdata;
  assign mix = w1 ^ w2 ^ w3 ^ kin;
  assign sub = tau(mix);
  assign lin = expanding ? (sub ^ rotl(sub, 13) ^ rotl(sub, 23))
                         : (sub ^ rotl(sub, 2) ^ rotl(sub, 10) ^ rotl(sub, 18) ^ rotl(sub, 24));
  assign nw  = w0 ^ lin;

  always_comb begin
    state_next = state;
    case (state)
      CORE_IDLE: begin
        if (ctrl.start_expand) state_next = CORE_EXPAND;
        else if (ctrl.start_encrypt) state_next = CORE_ENCRYPT;
      end
      CORE_EXPAND: begin
        if (ctrl.start_expand) state_next = CORE_EXPAND;
        else if (round == LAST_ROUND) state_next = CORE_IDLE;
      end
      CORE_ENCRYPT: begin
        if (ctrl.start_expand) state_next = CORE_EXPAND;
        else if (round == LAST_ROUND) state_next = CORE_IDLE;
      end
      default: state_next = CORE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CORE_IDLE;
      round <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == CORE_ENCRYPT) && (round == LAST_ROUND) && !ctrl.start_expand;
      if (ctrl.start_expand || (state == CORE_IDLE)) round <= '0;
      else round <= round + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start_expand) begin
      w0 <= key[127:96] ^ FK[0];
      w1 <= key[95:64]  ^ FK[1];
      w2 <= key[63:32]  ^ FK[2];
      w3 <= key[31:0]   ^ FK[3];
    end else if ((state == CORE_IDLE) && ctrl.start_encrypt) begin
      w0 <= block_in[127:96];
      w1 <= block_in[95:64];
      w2 <= block_in[63:32];
      w3 <= block_in[31:0];
    end else if (state != CORE_IDLE) begin
      w0 <= w1;
      w1 <= w2;
      w2 <= w3;
      w3 <= nw;
    end
  end

  always_ff @(posedge clk) begin
    if (expanding && !ctrl.start_expand) rk_mem[round] <= nw;
    rk_rdata <= rk_mem[rk_raddr];
  end

  assign status.busy = (state != CORE_IDLE);
  assign status.done = done;
  // Output words come out in reverse order.
  assign block_out   = {w3, w2, w1, w0};

endmodule

FILE: design/sm4c_checker.sv
// Port-level checks of the SM4 counter-mode cipher, bound to the top level.
// Depends on sm4c_pkg and sm4_ctr_stream_cipher.
module sm4c_checker (
  input logic        clk,
  input logic        rst,
  input logic        data_valid,
  input logic        data_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [63:0] result_high,
  input logic [63:0] result_low,
  input logic [4:0]  result_bytes
);
  import sm4c_pkg::*;

  // A stalled result stays and keeps its byte count.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_bytes))
    else $error("stalled result dropped or changed");

  // One request at a time: an accepted request closes the channel next cycle.
  a_one_open: assert property (@(posedge clk) disable iff (rst)
    data_valid && !data_stall |=> data_stall)
    else $error("request accepted while another is open");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_bytes <= 5'(BLOCK_BYTES))
    else $error("result byte count above a full block");

  // Words wholly past the byte count are zero.
  a_low_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_bytes <= 5'd8 |-> result_low == 64'd0)
    else $error("low word not cleared on a short block");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_bytes == 5'd0 |-> result_high == 64'd0)
    else $error("high word not cleared on an empty block");

endmodule

bind sm4_ctr_stream_cipher sm4c_checker u_sm4c_checker (.*);
